@@ src/audio_silence_gate_preroll_unit_assert.svh @@
// Assertion macros for the checker of the silence gate.
// Each macro expects signals named clk and rst in the enclosing scope.
`ifndef AUDIO_SILENCE_GATE_PREROLL_UNIT_ASSERT_SVH
`define AUDIO_SILENCE_GATE_PREROLL_UNIT_ASSERT_SVH

// Same-cycle implication
`define ASGP_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define ASGP_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/asgp_pkg.sv @@
`timescale 1ns / 1ps

package asgp_pkg;

  // Default sizes
  localparam int DEF_MAX_BLOCK_SAMPLES = 4096;
  localparam int DEF_HELD_DEPTH        = 16;

  // Field widths
  localparam int SAMPLE_W   = 16;
  localparam int TAG_W      = 64;
  localparam int LEN_OUT_W  = 13;
  localparam int KIND_W     = 2;
  localparam int THR_W      = 31;
  localparam int RUN_W      = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // Stream packing
  localparam int IN_DATA_W   = 80;
  localparam int OUT_DATA_W  = 80;
  localparam int OUT_LEN_LSB = TAG_W;

  // Register reset values
  localparam logic             RST_WIDTH_MODE  = 1'b0;
  localparam logic [THR_W-1:0] RST_THRESHOLD   = 31'd10737418;
  localparam logic [RUN_W-1:0] RST_RUN_LENGTH  = 32'd22050;
  localparam logic [RUN_W-1:0] RST_PREROLL_LEN = 32'd8820;
  localparam logic             RST_LEAKY       = 1'b0;

  // Result kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_START,
    KIND_STOP,
    KIND_FWD,
    KIND_DROP
  } kind_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIDTH_MODE,
    REG_THRESHOLD_SQ,
    REG_RUN_LENGTH,
    REG_PREROLL_LEN,
    REG_LEAKY
  } reg_index_t;

endpackage

@@ src/audio_silence_gate_preroll_unit.sv @@
`timescale 1ns / 1ps
// Each sample is accepted in S_IDLE, squared by the shared multiplier in S_SQR and summed in
// S_ACC; a closing sample then goes through S_THR to the gate decision in S_DEC. An audible
// block is forwarded before ready returns, a held block is appended to the pre-roll queue;
// events and held blocks that are flushed or trimmed add steps, and output stalls hold it.
// A new sample is taken only once the previous one has been squared and summed.
// Reset (synchronous, rst high): gate silent, sums and counts zero, pre-roll queue empty.

module audio_silence_gate_preroll_unit import asgp_pkg::*; #(
  parameter int MAX_BLOCK_SAMPLES = DEF_MAX_BLOCK_SAMPLES,
  parameter int HELD_DEPTH        = DEF_HELD_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst,
  // Input stream
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // [15:0] sample, [79:16] block_tag
  input  logic                  s_tlast,   // end_of_block
  // Output stream
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,   // [63:0] tag, [76:64] block_length, rest 0
  output logic [KIND_W-1:0]     m_tuser,   // [1:0] kind
  output logic                  m_tlast,   // last
  // Configuration writes
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int CNT_W  = $clog2(MAX_BLOCK_SAMPLES + 1);
  localparam int MB_W   = (CNT_W > SAMPLE_W) ? CNT_W : SAMPLE_W;
  localparam int PROD_W = THR_W + MB_W;
  localparam int SUM_W  = 2 * SAMPLE_W - 1 + CNT_W;
  localparam int PTR_W  = (HELD_DEPTH > 1) ? $clog2(HELD_DEPTH) : 1;
  localparam int HCNT_W = $clog2(HELD_DEPTH + 1);

  localparam logic [CNT_W-1:0]  MAX_CNT    = CNT_W'(MAX_BLOCK_SAMPLES);
  localparam logic [HCNT_W-1:0] DEPTH_CNT  = HCNT_W'(HELD_DEPTH);
  localparam logic [PTR_W:0]    DEPTH_SLOT = (PTR_W + 1)'(HELD_DEPTH);
  localparam logic [PTR_W-1:0]  LAST_PTR   = PTR_W'(HELD_DEPTH - 1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_SQR,
    S_ACC,
    S_THR,
    S_DEC,
    S_EVT,
    S_FLCHK,
    S_FULLCHK,
    S_APPEND,
    S_TRCHK,
    S_RD,
    S_POP,
    S_FWD,
    S_FIN
  } state_t;

  typedef enum logic [1:0] {
    MODE_FLUSH,
    MODE_FULL,
    MODE_TRIM
  } pop_mode_t;

  typedef struct packed {
    logic [TAG_W-1:0] tag;
    logic [CNT_W-1:0] len;
  } held_entry_t;

  // Configuration registers
  logic             width_mode;
  logic [THR_W-1:0] threshold_sq;
  logic [RUN_W-1:0] run_length;
  logic [RUN_W-1:0] preroll_len;
  logic             leaky;

  // Sequencer and block state
  state_t            state;
  pop_mode_t         mode;
  logic              silent_flag;
  logic [SUM_W-1:0]  square_sum;
  logic [CNT_W-1:0]  sample_count;
  logic [RUN_W-1:0]  silent_run;
  logic [RUN_W-1:0]  held_length;
  logic [PTR_W-1:0]  held_head;
  logic [HCNT_W-1:0] held_count;

  // Item registers
  logic [SAMPLE_W-1:0] mag;
  logic [TAG_W-1:0]    tag;
  logic                eob;
  logic [CNT_W-1:0]    len;
  logic [PROD_W-1:0]   prod;

  // Pending result, released once the next one or the end is known
  logic                 pend_valid;
  kind_t                pend_kind;
  logic [TAG_W-1:0]     pend_tag;
  logic [LEN_OUT_W-1:0] pend_len;

  // Pre-roll queue
  held_entry_t held_mem [HELD_DEPTH];
  held_entry_t rd_entry;

  // Combinational signals
  logic [SAMPLE_W-1:0]  mag_in;
  logic [7:0]           byte_mag;
  logic [THR_W-1:0]     mul_a;
  logic [MB_W-1:0]      mul_b;
  logic [PROD_W-1:0]    mul_p;
  logic [CNT_W-1:0]     count_inc;
  logic                 close;
  logic                 quiet;
  logic [RUN_W:0]       run_sum;
  logic [RUN_W-1:0]     run_next;
  logic                 flag_next;
  logic [RUN_W:0]       hl_sum;
  logic [RUN_W-1:0]     hl_add;
  logic [RUN_W-1:0]     hl_sub;
  logic [PTR_W:0]       slot_sum;
  logic [PTR_W-1:0]     slot;
  logic [PTR_W-1:0]     head_inc;
  logic                 out_free;
  logic                 gen_req;
  logic                 gen_go;
  kind_t                gen_kind;
  logic [TAG_W-1:0]     gen_tag;
  logic [LEN_OUT_W-1:0] gen_len;

  assign s_tready = (state == S_IDLE);
  assign out_free = !m_tvalid || m_tready;

  // Take the sample magnitude; 8-bit mode uses the low byte shifted up
  always_comb begin
    byte_mag = s_tdata[7] ? 8'(8'd0 - s_tdata[7:0]) : s_tdata[7:0];
    if (width_mode) begin
      mag_in = {byte_mag, 8'd0};
    end else begin
      mag_in = s_tdata[SAMPLE_W-1] ? SAMPLE_W'(17'h10000 - {1'b0, s_tdata[SAMPLE_W-1:0]})
                                   : s_tdata[SAMPLE_W-1:0];
    end
  end

  // Shared multiplier: square of the sample, or threshold times count
  always_comb begin
    if (state == S_SQR) begin
      mul_a = THR_W'(mag);
      mul_b = MB_W'(mag);
    end else begin
      mul_a = threshold_sq;
      mul_b = MB_W'(sample_count);
    end
    mul_p = mul_a * mul_b;
  end

  // Block close and gate decision
  always_comb begin
    count_inc = sample_count + CNT_W'(1);
    close     = eob || (count_inc >= MAX_CNT);
    quiet     = PROD_W'(square_sum) < prod;
    run_sum   = {1'b0, silent_run} + (RUN_W + 1)'(sample_count);
    if (quiet) begin
      run_next  = run_sum[RUN_W] ? '1 : run_sum[RUN_W-1:0];
      flag_next = silent_flag;
    end else begin
      run_next  = '0;
      flag_next = 1'b0;
    end
    if (run_next > run_length) begin
      flag_next = 1'b1;
    end
  end

  // Held length and queue pointers
  always_comb begin
    hl_sum   = {1'b0, held_length} + (RUN_W + 1)'(len);
    hl_add   = hl_sum[RUN_W] ? '1 : hl_sum[RUN_W-1:0];
    hl_sub   = (held_length > RUN_W'(rd_entry.len)) ? held_length - RUN_W'(rd_entry.len) : '0;
    slot_sum = {1'b0, held_head} + (PTR_W + 1)'(held_count);
    slot     = (slot_sum >= DEPTH_SLOT) ? PTR_W'(slot_sum - DEPTH_SLOT) : PTR_W'(slot_sum);
    head_inc = (held_head == LAST_PTR) ? '0 : held_head + PTR_W'(1);
  end

  // Result produced by the current step
  always_comb begin
    gen_req  = 1'b0;
    gen_kind = KIND_FWD;
    gen_tag  = tag;
    gen_len  = '0;
    case (state)
      S_EVT: begin
        gen_req  = 1'b1;
        gen_kind = silent_flag ? KIND_STOP : KIND_START;
      end
      S_POP: begin
        gen_req  = 1'b1;
        gen_kind = ((mode != MODE_FLUSH) && leaky) ? KIND_DROP : KIND_FWD;
        gen_tag  = rd_entry.tag;
        gen_len  = LEN_OUT_W'(rd_entry.len);
      end
      S_FWD: begin
        gen_req = 1'b1;
        gen_len = LEN_OUT_W'(len);
      end
      default: begin
      end
    endcase
    gen_go = gen_req && (!pend_valid || out_free);
  end

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      width_mode   <= RST_WIDTH_MODE;
      threshold_sq <= RST_THRESHOLD;
      run_length   <= RST_RUN_LENGTH;
      preroll_len  <= RST_PREROLL_LEN;
      leaky        <= RST_LEAKY;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WIDTH_MODE:   width_mode   <= cfg_data[0];
        REG_THRESHOLD_SQ: threshold_sq <= cfg_data[THR_W-1:0];
        REG_RUN_LENGTH:   run_length   <= cfg_data[RUN_W-1:0];
        REG_PREROLL_LEN:  preroll_len  <= cfg_data[RUN_W-1:0];
        REG_LEAKY:        leaky        <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // Append at the tail, read the head
  always_ff @(posedge clk) begin
    if (state == S_APPEND) begin
      held_mem[slot] <= '{tag: tag, len: len};
    end
    if (state == S_RD) begin
      rd_entry <= held_mem[held_head];
    end
  end

  // Sequencer, block state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      silent_flag  <= 1'b1;
      square_sum   <= '0;
      sample_count <= '0;
      silent_run   <= '0;
      held_length  <= '0;
      held_head    <= '0;
      held_count   <= '0;
      pend_valid   <= 1'b0;
      m_tvalid     <= 1'b0;
    end else begin
      // Release the pending result: not last while a newer one follows, last at the end
      if (gen_go && pend_valid) begin
        m_tvalid <= 1'b1;
        m_tuser  <= pend_kind;
        m_tdata  <= OUT_DATA_W'({pend_len, pend_tag});
        m_tlast  <= 1'b0;
      end else if ((state == S_FIN) && pend_valid && out_free) begin
        m_tvalid <= 1'b1;
        m_tuser  <= pend_kind;
        m_tdata  <= OUT_DATA_W'({pend_len, pend_tag});
        m_tlast  <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end

      // Hold the new result
      if (gen_go) begin
        pend_valid <= 1'b1;
        pend_kind  <= gen_kind;
        pend_tag   <= gen_tag;
        pend_len   <= gen_len;
      end

      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            mag   <= mag_in;
            tag   <= s_tdata[IN_DATA_W-1:SAMPLE_W];
            eob   <= s_tlast;
            state <= S_SQR;
          end
        end
        S_SQR: begin
          prod  <= mul_p;
          state <= S_ACC;
        end
        S_ACC: begin
          square_sum   <= square_sum + SUM_W'(prod);
          sample_count <= count_inc;
          state        <= close ? S_THR : S_IDLE;
        end
        S_THR: begin
          prod  <= mul_p;
          state <= S_DEC;
        end
        S_DEC: begin
          silent_run   <= run_next;
          silent_flag  <= flag_next;
          len          <= sample_count;
          square_sum   <= '0;
          sample_count <= '0;
          if (flag_next != silent_flag) begin
            state <= S_EVT;
          end else begin
            state <= flag_next ? S_FULLCHK : S_FWD;
          end
        end
        S_EVT: begin
          if (gen_go) begin
            state <= silent_flag ? S_FULLCHK : S_FLCHK;
          end
        end
        S_FLCHK: begin
          if (held_count != '0) begin
            mode  <= MODE_FLUSH;
            state <= S_RD;
          end else begin
            held_length <= '0;
            state       <= S_FWD;
          end
        end
        S_FULLCHK: begin
          if (held_count >= DEPTH_CNT) begin
            mode  <= MODE_FULL;
            state <= S_RD;
          end else begin
            state <= S_APPEND;
          end
        end
        S_APPEND: begin
          held_count  <= held_count + HCNT_W'(1);
          held_length <= hl_add;
          state       <= S_TRCHK;
        end
        S_TRCHK: begin
          if ((held_length > preroll_len) && (held_count != '0)) begin
            mode  <= MODE_TRIM;
            state <= S_RD;
          end else begin
            state <= S_FIN;
          end
        end
        S_RD: begin
          state <= S_POP;
        end
        S_POP: begin
          if (gen_go) begin
            held_head   <= head_inc;
            held_count  <= held_count - HCNT_W'(1);
            held_length <= hl_sub;
            case (mode)
              MODE_FLUSH: state <= S_FLCHK;
              MODE_FULL:  state <= S_APPEND;
              default:    state <= S_TRCHK;
            endcase
          end
        end
        S_FWD: begin
          if (gen_go) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          // Finish once the final result has gone to the output register
          if (!pend_valid) begin
            state <= S_IDLE;
          end else if (out_free) begin
            pend_valid <= 1'b0;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ src/asgp_checker.sv @@
`timescale 1ns / 1ps
`include "audio_silence_gate_preroll_unit_assert.svh"

module asgp_checker import asgp_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  s_tvalid,
  input logic                  s_tready,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [OUT_DATA_W-1:0] m_tdata,
  input logic [KIND_W-1:0]     m_tuser,
  input logic                  m_tlast
);

  // Hold a stalled result
  `ASGP_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "stalled result changed")

  // Ready is low in the cycle after each accepted request
  `ASGP_ASSERT_NXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "ready held after request")

  // Events carry no block length
  `ASGP_ASSERT_IMP(a_event_len, m_tvalid && (m_tuser == KIND_START || m_tuser == KIND_STOP), m_tdata[OUT_LEN_LSB+LEN_OUT_W-1:OUT_LEN_LSB] == '0, "event with nonzero length")

  // A start is never marked last, since a forward of the same block always follows it
  `ASGP_ASSERT_IMP(a_start_not_last, m_tvalid && (m_tuser == KIND_START), !m_tlast, "cut start marked last")

endmodule

bind audio_silence_gate_preroll_unit asgp_checker u_asgp_checker (.*);
